[rtl/apsp_pkg.sv]
// Shared constants, codes and controller/datapath interface types for the shortest path block.
package apsp_pkg;

  // Sizing
  localparam int MAX_NODES    = 16;
  localparam int WEIGHT_BITS  = 16;
  localparam int NODE_BITS    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int ADDR_BITS    = 2 * NODE_BITS;
  localparam int DEPTH        = 1 << ADDR_BITS;
  localparam int CNT_BITS     = $clog2(MAX_NODES + 1);

  // Field widths
  localparam int IDX_BITS     = 4;
  localparam int WFIELD_BITS  = 16;
  localparam int LEN_BITS     = 20;
  localparam int DIST_BITS    = 21;

  localparam logic [DIST_BITS-1:0]   MAX_FINITE  = 21'h0F_FFFF;
  localparam logic [DIST_BITS-1:0]   INF_CODE    = 21'h1F_FFFF;
  localparam logic [WFIELD_BITS-1:0] WEIGHT_MASK =
    WFIELD_BITS'((64'd1 << WEIGHT_BITS) - 64'd1);

  // Request operation codes
  typedef enum logic [1:0] {
    OP_SET_DIR   = 2'd0,
    OP_SET_UNDIR = 2'd1,
    OP_RUN       = 2'd2,
    OP_READ      = 2'd3
  } op_e;

  typedef logic [NODE_BITS-1:0] node_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic  latch;      // capture the request fields
    logic  set_fwd;    // write entry [a][b]
    logic  set_rev;    // write entry [b][a]
    logic  row_rd;     // fetch entry [i][k] for a new row
    logic  step;       // issue one relaxation step (k, i, j)
    logic  cap;        // capture the fetched [i][k] entry
    logic  emit;       // register a result
    logic  emit_read;  // result carries the fetched entry
    node_t k;
    node_t i;
    node_t j;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [CNT_BITS-1:0] n;  // nodes in use
  } sts_t;

endpackage

[rtl/apsp_ctrl.sv]
// Sequencer for edge writes, entry reads and the Floyd-Warshall triple loop.
module apsp_ctrl import apsp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  logic [1:0] op_i,
  input  sts_t       sts_i,
  output logic       busy,
  output cmd_t       cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SET_FWD,
    ST_SET_REV,
    ST_RD_ISSUE,
    ST_RD_EMIT,
    ST_RUN_ROW,
    ST_RUN_STEP,
    ST_RUN_DRAIN,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;
  op_e    op_q, op_d;
  node_t  k_q, k_d, i_q, i_d, j_q, j_d;
  logic   busy_q;
  logic   last_k, last_i, last_j;

  assign last_k = (CNT_BITS'(k_q) + CNT_BITS'(1)) == sts_i.n;
  assign last_i = (CNT_BITS'(i_q) + CNT_BITS'(1)) == sts_i.n;
  assign last_j = (CNT_BITS'(j_q) + CNT_BITS'(1)) == sts_i.n;

  // Next state, loop counters and commands
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    k_d     = k_q;
    i_d     = i_q;
    j_d     = j_q;
    cmd_o   = '0;
    cmd_o.k = k_q;
    cmd_o.i = i_q;
    cmd_o.j = j_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.latch = 1'b1;
          op_d        = op_e'(op_i);
          k_d         = '0;
          i_d         = '0;
          j_d         = '0;
          case (op_e'(op_i))
            OP_SET_DIR, OP_SET_UNDIR: state_d = ST_SET_FWD;
            OP_READ:                  state_d = ST_RD_ISSUE;
            OP_RUN:                   state_d = (sts_i.n == '0) ? ST_EMIT : ST_RUN_ROW;
            default:                  state_d = ST_EMIT;
          endcase
        end
      end
      ST_SET_FWD: begin
        cmd_o.set_fwd = 1'b1;
        if (op_q == OP_SET_UNDIR) begin
          state_d = ST_SET_REV;
        end else begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      ST_SET_REV: begin
        cmd_o.set_rev = 1'b1;
        cmd_o.emit    = 1'b1;
        state_d       = ST_IDLE;
      end
      ST_RD_ISSUE: begin
        // datapath addresses [a][b] by default
        state_d = ST_RD_EMIT;
      end
      ST_RD_EMIT: begin
        cmd_o.emit      = 1'b1;
        cmd_o.emit_read = 1'b1;
        state_d         = ST_IDLE;
      end
      ST_RUN_ROW: begin
        cmd_o.row_rd = 1'b1;
        j_d          = '0;
        state_d      = ST_RUN_STEP;
      end
      ST_RUN_STEP: begin
        cmd_o.step = 1'b1;
        cmd_o.cap  = (j_q == '0);
        if (last_j) begin
          j_d = '0;
          if (last_i) begin
            i_d = '0;
            if (last_k) begin
              state_d = ST_RUN_DRAIN;
            end else begin
              k_d     = k_q + node_t'(1);
              state_d = ST_RUN_ROW;
            end
          end else begin
            i_d     = i_q + node_t'(1);
            state_d = ST_RUN_ROW;
          end
        end else begin
          j_d = j_q + node_t'(1);
        end
      end
      ST_RUN_DRAIN, ST_EMIT: begin
        cmd_o.emit = 1'b1;
        state_d    = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State, counters and busy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_SET_DIR;
      k_q     <= '0;
      i_q     <= '0;
      j_q     <= '0;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      k_q     <= k_d;
      i_q     <= i_d;
      j_q     <= j_d;
      busy_q  <= (state_d != ST_IDLE);
    end
  end

  assign busy = busy_q;

endmodule

[rtl/apsp_datapath.sv]
// Distance matrix memory, node bookkeeping, relaxation pipeline and result registers.
module apsp_datapath import apsp_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cmd_t                   cmd_i,
  input  logic [IDX_BITS-1:0]    node_a_i,
  input  logic [IDX_BITS-1:0]    node_b_i,
  input  logic [WFIELD_BITS-1:0] weight_i,
  output sts_t                   sts_o,
  output logic                   result_valid_o,
  output logic [LEN_BITS-1:0]    path_length_o,
  output logic                   no_path_o
);

  typedef logic [DIST_BITS-1:0] dist_t;
  typedef logic [ADDR_BITS-1:0] addr_t;

  // Missing off-diagonal edge reads as infinity during a run
  function automatic dist_t eff(input dist_t raw, input logic off);
    return (off && (raw == '0)) ? INF_CODE : raw;
  endfunction

  // Saturating add to infinity
  function automatic dist_t sat_add(input dist_t x, input dist_t y);
    logic [DIST_BITS:0] s;
    s = {1'b0, x} + {1'b0, y};
    if ((x == INF_CODE) || (y == INF_CODE) || (s > {1'b0, MAX_FINITE})) begin
      return INF_CODE;
    end
    return s[DIST_BITS-1:0];
  endfunction

  // Latched request
  node_t                   a_q, b_q;
  logic                    in_range_q;
  dist_t                   w_q;
  logic [WFIELD_BITS-1:0]  w_mask;
  dist_t                   w_store;

  assign w_mask  = weight_i & WEIGHT_MASK;
  assign w_store = (32'(w_mask) > 32'(MAX_FINITE)) ? INF_CODE : DIST_BITS'(w_mask);

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      a_q        <= NODE_BITS'(node_a_i);
      b_q        <= NODE_BITS'(node_b_i);
      in_range_q <= (32'(node_a_i) < MAX_NODES) && (32'(node_b_i) < MAX_NODES);
      w_q        <= w_store;
    end
  end

  // Node presence map and count
  logic [MAX_NODES-1:0] present_q;
  logic [CNT_BITS-1:0]  count_q;
  logic                 new_a, new_b;

  assign new_a = !present_q[a_q];
  assign new_b = !present_q[b_q] && (a_q != b_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= '0;
      count_q   <= '0;
    end else if (cmd_i.set_fwd && in_range_q) begin
      present_q <= present_q | (MAX_NODES'(1) << a_q) | (MAX_NODES'(1) << b_q);
      count_q   <= count_q + CNT_BITS'(new_a) + CNT_BITS'(new_b);
    end
  end

  assign sts_o.n = count_q;

  // Relaxation stage registers
  logic  s1_vld_q;
  addr_t s1_addr_q;
  logic  s1_kj_off_q, s1_ij_off_q;
  dist_t dik_q;

  // Memory ports
  dist_t                mem_q [DEPTH];
  logic [DEPTH-1:0]     vld_q;
  addr_t                rd_a_addr, rd_b_addr, wr_addr;
  dist_t                rd_a_q, rd_b_q, wr_data;
  logic                 rd_a_vld_q, rd_b_vld_q, wr_en;
  dist_t                raw_a, raw_b, eff_a, eff_b, sum, relaxed;

  always_comb begin
    if (cmd_i.step) begin
      rd_a_addr = {cmd_i.k, cmd_i.j};
    end else if (cmd_i.row_rd) begin
      rd_a_addr = {cmd_i.i, cmd_i.k};
    end else begin
      rd_a_addr = {a_q, b_q};
    end
  end
  assign rd_b_addr = {cmd_i.i, cmd_i.j};

  assign raw_a   = rd_a_vld_q ? rd_a_q : '0;
  assign raw_b   = rd_b_vld_q ? rd_b_q : '0;
  assign eff_a   = eff(raw_a, s1_kj_off_q);
  assign eff_b   = eff(raw_b, s1_ij_off_q);
  assign sum     = sat_add(dik_q, eff_a);
  assign relaxed = (sum < eff_b) ? sum : eff_b;

  // Write port: edge sets or relaxation write-back
  always_comb begin
    wr_en   = s1_vld_q;
    wr_addr = s1_addr_q;
    wr_data = relaxed;
    if (cmd_i.set_fwd || cmd_i.set_rev) begin
      wr_en   = in_range_q;
      wr_addr = cmd_i.set_fwd ? {a_q, b_q} : {b_q, a_q};
      wr_data = w_q;
    end
  end

  // Matrix storage, read data registered
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_a_q <= mem_q[rd_a_addr];
    rd_b_q <= mem_q[rd_b_addr];
  end

  // Entry valid bits: unwritten entries read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= '0;
      rd_a_vld_q <= 1'b0;
      rd_b_vld_q <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_q[wr_addr] <= 1'b1;
      end
      rd_a_vld_q <= vld_q[rd_a_addr];
      rd_b_vld_q <= vld_q[rd_b_addr];
    end
  end

  // Step pipeline control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= cmd_i.step;
    end
  end

  // Step pipeline payload; [i][k] held for the whole row
  always_ff @(posedge clk_i) begin
    s1_addr_q   <= {cmd_i.i, cmd_i.j};
    s1_kj_off_q <= (cmd_i.k != cmd_i.j);
    s1_ij_off_q <= (cmd_i.i != cmd_i.j);
    if (cmd_i.cap) begin
      dik_q <= eff(raw_a, cmd_i.i != cmd_i.k);
    end
  end

  // Result registers
  logic                res_vld_q;
  logic [LEN_BITS-1:0] len_q;
  logic                nop_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      if (cmd_i.emit_read && in_range_q) begin
        nop_q <= (raw_a == INF_CODE);
        len_q <= (raw_a == INF_CODE) ? '0 : raw_a[LEN_BITS-1:0];
      end else begin
        nop_q <= 1'b0;
        len_q <= '0;
      end
    end
  end

  assign result_valid_o = res_vld_q;
  assign path_length_o  = len_q;
  assign no_path_o      = nop_q;

endmodule

[rtl/all_pairs_shortest_path.sv]
// Top level of the all-pairs shortest path block: controller plus datapath.
//
//  Channel   Handshake                    Payload
//  --------  ---------------------------  -----------------------------------
//  request   start && !busy               op_i, node_a_i, node_b_i, weight_i
//  result    result_valid_o, one cycle    path_length_o, no_path_o
//
// A directed set writes [a][b], an undirected set also writes [b][a], and a read
// fetches [a][b]. With n nodes in use and n above 0, a run's time is set by the
// k/i/j loop, one relaxation per cycle through the two read ports of the
// matrix memory plus one row fetch per (k, i); with n of 0 it goes straight to the result.
// The result strobe follows in the cycle after the last busy cycle and may
// overlap a new request. Reset clears the matrix through per-entry valid
// bits at once; the receiver cannot stall, so results never wait.
module all_pairs_shortest_path import apsp_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             op_i,
  input  logic [IDX_BITS-1:0]    node_a_i,
  input  logic [IDX_BITS-1:0]    node_b_i,
  input  logic [WFIELD_BITS-1:0] weight_i,
  output logic                   result_valid_o,
  output logic [LEN_BITS-1:0]    path_length_o,
  output logic                   no_path_o
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer
  apsp_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .op_i   (op_i),
    .sts_i  (sts),
    .busy   (busy),
    .cmd_o  (cmd)
  );

  // Matrix and arithmetic
  apsp_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .node_a_i       (node_a_i),
    .node_b_i       (node_b_i),
    .weight_i       (weight_i),
    .sts_o          (sts),
    .result_valid_o (result_valid_o),
    .path_length_o  (path_length_o),
    .no_path_o      (no_path_o)
  );

endmodule
